// File: rtl/deq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit: operation and
// status codes, default capacity and the pending-result record.
// ----------------------------------------------------------------------------
package deq_pkg;

   localparam int DEF_CAPACITY = 256;
   localparam int WORD_W       = 32;
   localparam int OP_W         = 3;
   localparam int STATUS_W     = 2;
   localparam int COUNT_OUT_W  = 9;

   typedef enum logic [OP_W-1:0] {
      OP_PUSH_FRONT = 3'd0,
      OP_PUSH_BACK  = 3'd1,
      OP_POP_FRONT  = 3'd2,
      OP_POP_BACK   = 3'd3,
      OP_CLEAR      = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_DONE  = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // Result of one operation, held while the store read completes
   typedef struct packed {
      logic                   rd;
      status_type             status;
      logic [COUNT_OUT_W-1:0] count;
   } pend_type;

endpackage
`default_nettype wire

// File: rtl/deq_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ram
// Generic single-port synchronous RAM with registered read data. Read data
// holds its value until the next read.
// ----------------------------------------------------------------------------
module deq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/deq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// deq_ctrl
// Front/back index and count keeper. Decodes one operation per accepted
// beat, drives the store access and forms the pending result.
// ----------------------------------------------------------------------------
module deq_ctrl #(
   parameter int CAPACITY = deq_pkg::DEF_CAPACITY,
   localparam int IDX_W = $clog2(CAPACITY),
   localparam int CNT_W = $clog2(CAPACITY + 1)
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             accept,
   input  wire logic [deq_pkg::OP_W-1:0]         operation,
   input  wire logic signed [deq_pkg::WORD_W-1:0] push_value,
   output logic                                  mem_wr_en,
   output logic                                  mem_rd_en,
   output logic      [IDX_W-1:0]                 mem_addr,
   output logic      [deq_pkg::WORD_W-1:0]       mem_wr_data,
   output deq_pkg::pend_type                     pend
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(CAPACITY);

   logic [IDX_W-1:0] front_ff, front_in;
   logic [IDX_W-1:0] back_ff, back_in;
   logic [CNT_W-1:0] count_ff, count_in;

   logic [IDX_W-1:0] front_prev, front_next, back_prev, back_next;
   logic             full, empty;
   logic             wr, rd;
   logic [IDX_W-1:0] addr;
   deq_pkg::status_type status;
   logic [CNT_W+deq_pkg::COUNT_OUT_W-1:0] count_wide;

   // Wrap the indices around the circular store
   assign front_prev = (front_ff == '0) ? LAST_IDX : front_ff - IDX_W'(1);
   assign front_next = (front_ff == LAST_IDX) ? '0 : front_ff + IDX_W'(1);
   assign back_prev  = (back_ff == '0) ? LAST_IDX : back_ff - IDX_W'(1);
   assign back_next  = (back_ff == LAST_IDX) ? '0 : back_ff + IDX_W'(1);

   assign full  = (count_ff == FULL_CNT);
   assign empty = (count_ff == '0);

   // Decode the operation
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      count_in = count_ff;
      wr       = 1'b0;
      rd       = 1'b0;
      addr     = front_ff;
      status   = deq_pkg::ST_DONE;
      case (deq_pkg::op_type'(operation))
         deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               status = deq_pkg::ST_FULL;
            end else begin
               front_in = front_prev;
               addr     = front_prev;
               wr       = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::OP_PUSH_BACK: begin
            if (full) begin
               status = deq_pkg::ST_FULL;
            end else begin
               addr     = back_ff;
               back_in  = back_next;
               wr       = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         deq_pkg::OP_POP_FRONT: begin
            if (empty) begin
               status = deq_pkg::ST_EMPTY;
            end else begin
               addr     = front_ff;
               front_in = front_next;
               rd       = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::OP_POP_BACK: begin
            if (empty) begin
               status = deq_pkg::ST_EMPTY;
            end else begin
               back_in  = back_prev;
               addr     = back_prev;
               rd       = 1'b1;
               count_in = count_ff - CNT_W'(1);
            end
         end
         deq_pkg::OP_CLEAR: begin
            front_in = '0;
            back_in  = '0;
            count_in = '0;
         end
         default: begin
         end
      endcase
   end

   // Advance indices and count on an accepted beat
   always_ff @(posedge clock) begin
      if (reset) begin
         front_ff <= '0;
         back_ff  <= '0;
         count_ff <= '0;
      end else if (accept) begin
         front_ff <= front_in;
         back_ff  <= back_in;
         count_ff <= count_in;
      end
   end

   // Drive the store and the pending result
   assign count_wide  = {{deq_pkg::COUNT_OUT_W{1'b0}}, count_in};
   assign mem_wr_en   = accept && wr;
   assign mem_rd_en   = accept && rd;
   assign mem_addr    = addr;
   assign mem_wr_data = push_value;
   assign pend.rd     = rd;
   assign pend.status = status;
   assign pend.count  = count_wide[deq_pkg::COUNT_OUT_W-1:0];

endmodule
`default_nettype wire

// File: rtl/double_ended_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of 32-bit signed words in a circular store.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one operation per beat: push front, push back,
//   pop front, pop back or clear, with the word to push. The rsp_ channel
//   returns exactly one beat per request: the popped word (-1 when the queue
//   was empty or the operation is not a pop), a status (done, empty on pop,
//   full on push) and the number of words held afterwards.
//   A request beat passes through the store read and then the output register
//   before its result beat. Throughput is one operation per cycle while the
//   output is not stalled; the single-port store takes one access per cycle
//   and the index/count update completes in the accept cycle.
//   Reset clears both indices and the count; the store is not cleared and
//   needs no sweep, since only entries written by a push are ever read.
//   When rsp_stall holds the output register, the one operation in flight
//   waits with its read data held and req_stall rises until it moves on.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
   parameter int CAPACITY = deq_pkg::DEF_CAPACITY
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [deq_pkg::OP_W-1:0]            req_operation,
   input  wire logic signed [deq_pkg::WORD_W-1:0]   req_push_value,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic signed [deq_pkg::WORD_W-1:0]        rsp_pop_value,
   output logic      [deq_pkg::STATUS_W-1:0]        rsp_status,
   output logic      [deq_pkg::COUNT_OUT_W-1:0]     rsp_entry_count
);

   localparam int IDX_W = $clog2(CAPACITY);

   logic                          accept, out_free, finish;
   logic                          busy_ff, busy_in;
   deq_pkg::pend_type             pend, pend_ff;
   logic                          mem_wr_en, mem_rd_en;
   logic [IDX_W-1:0]              mem_addr;
   logic [deq_pkg::WORD_W-1:0]    mem_wr_data, mem_rd_data;

   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [deq_pkg::WORD_W-1:0]           rsp_pop_value_ff;
   deq_pkg::status_type                  rsp_status_ff;
   logic [deq_pkg::COUNT_OUT_W-1:0]      rsp_entry_count_ff;

   // Handshake control
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = busy_ff && out_free;
   assign req_stall = busy_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   assign busy_in      = accept ? 1'b1 : (finish ? 1'b0 : busy_ff);
   assign rsp_valid_in = finish ? 1'b1 : (rsp_valid_ff && rsp_stall);

   deq_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .operation   (req_operation),
      .push_value  (req_push_value),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data),
      .pend        (pend)
   );

   deq_ram #(
      .WIDTH (deq_pkg::WORD_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the pending result while the store read completes
   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend;
      end
   end

   // Load the output register when it is free
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_pop_value_ff   <= pend_ff.rd ? mem_rd_data : '1;
         rsp_status_ff      <= pend_ff.status;
         rsp_entry_count_ff <= pend_ff.count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pop_value   = rsp_pop_value_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

endmodule
`default_nettype wire

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for double_ended_queue_unit. A directed table covers
// the empty corner, both ends, every operation code and the spare
// codes. Randomized fill, drain and mixed phases then follow. Every
// result beat is checked against a queue-based predictor or a typed table
// row, and both channels idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
   import deq_pkg::*;

   localparam int CAPACITY        = DEF_CAPACITY;
   localparam int RESET_CYCLES    = 11;
   localparam int RANDOM_ITEMS    = 1300;
   localparam int HOLD_OFF_AT     = 200;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SETTLE_AT       = 700;
   localparam int TAIL_CYCLES     = 20;
   localparam int CYCLE_LIMIT     = 600000;

   localparam logic signed [WORD_W-1:0] NO_WORD  = -1;
   localparam logic signed [WORD_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;

   // Spare operation codes: the block treats them as no-ops
   localparam logic [OP_W-1:0] OP_NOP_A = 3'd5;
   localparam logic [OP_W-1:0] OP_NOP_B = 3'd6;
   localparam logic [OP_W-1:0] OP_NOP_C = 3'd7;

   typedef enum int {PHASE_FILL, PHASE_DRAIN, PHASE_MIXED} phase_kind_type;

   typedef struct packed {
      logic signed [WORD_W-1:0]   pop_value;
      logic [STATUS_W-1:0]        status;
      logic [COUNT_OUT_W-1:0]     entry_count;
   } deque_beat_type;

   // One directed step; the result fields count only when typed is set
   typedef struct packed {
      logic [OP_W-1:0]            op;
      logic signed [WORD_W-1:0]   value;
      logic                       typed;
      deque_beat_type             beat;
   } plan_row_type;

   localparam int DIRECTED_ROWS = 24;
   localparam plan_row_type DIRECTED_PLAN [DIRECTED_ROWS] = '{
      // empty queue right after reset, both ends
      '{OP_POP_FRONT,  32'sd0,        1'b1, '{NO_WORD, ST_EMPTY, 9'd0}},
      '{OP_POP_BACK,   32'sd0,        1'b1, '{NO_WORD, ST_EMPTY, 9'd0}},
      // front push wraps the front index below zero
      '{OP_PUSH_FRONT, WORD_MIN,      1'b1, '{NO_WORD, ST_DONE,  9'd1}},
      '{OP_POP_BACK,   32'sd0,        1'b0, '0},
      '{OP_PUSH_BACK,  WORD_MAX,      1'b0, '0},
      '{OP_PUSH_FRONT, 32'sd0,        1'b0, '0},
      '{OP_PUSH_BACK,  NO_WORD,       1'b0, '0},
      '{OP_PUSH_FRONT, 32'sh5555_5555, 1'b0, '0},
      '{OP_PUSH_BACK,  32'shAAAA_AAAA, 1'b0, '0},
      // spare codes leave the contents alone
      '{OP_NOP_A,      32'sh1234_5678, 1'b0, '0},
      '{OP_NOP_B,      WORD_MAX,      1'b0, '0},
      '{OP_NOP_C,      WORD_MIN,      1'b0, '0},
      '{OP_POP_FRONT,  32'sd0,        1'b0, '0},
      '{OP_POP_BACK,   32'sd0,        1'b0, '0},
      '{OP_POP_BACK,   32'sd0,        1'b0, '0},
      '{OP_POP_FRONT,  32'sd0,        1'b0, '0},
      '{OP_POP_FRONT,  32'sd0,        1'b0, '0},
      '{OP_POP_BACK,   32'sd0,        1'b1, '{NO_WORD, ST_EMPTY, 9'd0}},
      // clear with words held, then reuse from the reset indices
      '{OP_PUSH_BACK,  32'sd1,        1'b0, '0},
      '{OP_PUSH_FRONT, 32'sd2,        1'b0, '0},
      '{OP_CLEAR,      WORD_MAX,      1'b1, '{NO_WORD, ST_DONE,  9'd0}},
      '{OP_POP_FRONT,  32'sd0,        1'b1, '{NO_WORD, ST_EMPTY, 9'd0}},
      '{OP_PUSH_BACK,  32'sd3,        1'b0, '0},
      '{OP_POP_FRONT,  32'sd0,        1'b0, '0}
   };

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_operation = OP_CLEAR;
   logic signed [WORD_W-1:0] req_push_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic signed [WORD_W-1:0] rsp_pop_value;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_OUT_W-1:0]   rsp_entry_count;

   // Beats as sampled in the low half of the cycle, acted on at the edge
   logic                     req_take = 1'b0;
   logic                     rsp_take = 1'b0;
   deque_beat_type           rsp_seen;

   logic signed [WORD_W-1:0] deque_words [$];
   deque_beat_type           expected_beats [$];

   logic burst_mode       = 1'b0;
   logic hold_off_request = 1'b0;
   int   error_count      = 0;
   int   cycle_count      = 0;
   int   requests_sent    = 0;
   int   refused_pushes   = 0;
   int   empty_pops       = 0;
   int   peak_count       = 0;

   double_ended_queue_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_push_value  (req_push_value),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_pop_value   (rsp_pop_value),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Apply one operation to the queue copy and return the beat it yields
   function automatic deque_beat_type predict_deque_op(logic [OP_W-1:0] op,
                                                       logic signed [WORD_W-1:0] value);
      deque_beat_type beat;
      beat.pop_value = NO_WORD;
      beat.status    = ST_DONE;
      case (op)
         OP_PUSH_FRONT, OP_PUSH_BACK: begin
            if (deque_words.size() >= CAPACITY) begin
               beat.status = ST_FULL;
               refused_pushes++;
            end else if (op == OP_PUSH_FRONT) begin
               deque_words.push_front(value);
            end else begin
               deque_words.insert(deque_words.size(), value);
            end
         end
         OP_POP_FRONT, OP_POP_BACK: begin
            if (deque_words.size() == 0) begin
               beat.status = ST_EMPTY;
               empty_pops++;
            end else if (op == OP_POP_FRONT) begin
               beat.pop_value = deque_words.pop_front();
            end else begin
               beat.pop_value = deque_words.pop_back();
            end
         end
         OP_CLEAR: deque_words.delete();
         default: ;
      endcase
      if (deque_words.size() > peak_count) peak_count = deque_words.size();
      beat.entry_count = COUNT_OUT_W'(deque_words.size());
      return beat;
   endfunction

   task automatic report_mismatch(string what, logic [WORD_W-1:0] want,
                                  logic [WORD_W-1:0] got);
      $display("mismatch in %s at cycle %0d: expected %h, got %h",
               what, cycle_count, want, got);
      error_count++;
   endtask

   // Idle the request side for a random stretch, mostly short
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (burst_mode || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Offer one request beat, hold it until accepted, then log its result
   task automatic send_request(logic [OP_W-1:0] op, logic signed [WORD_W-1:0] value,
                               logic use_typed, deque_beat_type typed_beat);
      int             gap;
      deque_beat_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_operation  <= op;
      req_push_value <= value;
      do @(posedge clock); while (!req_take);
      predicted = predict_deque_op(op, value);
      expected_beats.insert(expected_beats.size(), use_typed ? typed_beat : predicted);
      requests_sent++;
   endtask

   // Sample both handshakes at the falling edge ahead of the edge that takes them
   always @(negedge clock) begin
      req_take = !reset && req_valid && !req_stall;
      rsp_take = !reset && rsp_valid && !rsp_stall;
      rsp_seen = '{rsp_pop_value, rsp_status, rsp_entry_count};
   end

   // Drive result stalls; serve one long hold-off on request
   always @(posedge clock) begin
      static int  stall_left = 0;
      static logic hold_served = 1'b0;
      int r;
      r = $urandom_range(0, 99);
      if (hold_off_request && !hold_served) begin
         hold_served = 1'b1;
         stall_left  = HOLD_OFF_CYCLES - 1;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (reset || burst_mode || r < 70) begin
         rsp_stall <= 1'b0;
      end else if (r < 96) begin
         stall_left = $urandom_range(0, 2);
         rsp_stall <= 1'b1;
      end else begin
         stall_left = $urandom_range(15, 50);
         rsp_stall <= 1'b1;
      end
   end

   // Check each result beat against the oldest expectation
   always @(posedge clock) begin
      deque_beat_type want;
      if (rsp_take) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected result beat", '0, rsp_seen.pop_value);
         end else begin
            want = expected_beats.pop_front();
            if (rsp_seen.pop_value !== want.pop_value)
               report_mismatch("pop_value", want.pop_value, rsp_seen.pop_value);
            if (rsp_seen.status !== want.status)
               report_mismatch("status", WORD_W'(want.status),
                               WORD_W'(rsp_seen.status));
            if (rsp_seen.entry_count !== want.entry_count)
               report_mismatch("entry_count", WORD_W'(want.entry_count),
                               WORD_W'(rsp_seen.entry_count));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_beats.size());
         $display("FAIL");
         $finish;
      end
   end

   // Stimulus: reset, directed table, then randomized phases
   initial begin
      phase_kind_type           phase;
      int                       phase_left;
      int                       r;
      logic [OP_W-1:0]          op;
      logic signed [WORD_W-1:0] word;

      phase      = PHASE_FILL;
      phase_left = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the directed table
      for (int i = 0; i < DIRECTED_ROWS; i++)
         send_request(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].value,
                      DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].beat);

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // pick the next phase: fill to capacity, drain past empty, or mix
         if (phase_left == 0) begin
            r = $urandom_range(0, 4);
            if (n == 0 || r < 2) begin
               phase      = PHASE_FILL;
               phase_left = $urandom_range(270, 330);
            end else if (r < 4) begin
               phase      = PHASE_DRAIN;
               phase_left = $urandom_range(270, 330);
            end else begin
               phase      = PHASE_MIXED;
               phase_left = $urandom_range(40, 150);
            end
            burst_mode = ($urandom_range(0, 4) == 0);
         end
         phase_left--;

         // hold the result side off for a long stretch while requests keep coming
         if (n == HOLD_OFF_AT) hold_off_request = 1'b1;

         // pause until every pending result has come back
         if (n == SETTLE_AT) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (expected_beats.size() != 0);
         end

         word = $urandom;
         if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
               0: word = WORD_MIN;
               1: word = WORD_MAX;
               2: word = '0;
               default: word = NO_WORD;
            endcase
         end

         r = $urandom_range(0, 99);
         case (phase)
            PHASE_FILL: begin
               if (r < 94)      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
               else if (r < 99) op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
               else             op = OP_W'($urandom_range(OP_NOP_A, OP_NOP_C));
            end
            PHASE_DRAIN: begin
               if (r < 90)      op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
               else if (r < 97) op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
               else             op = OP_W'($urandom_range(OP_NOP_A, OP_NOP_C));
            end
            default: begin
               if (r < 46)      op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
               else if (r < 92) op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
               else if (r < 95) op = OP_CLEAR;
               else             op = OP_W'($urandom_range(OP_NOP_A, OP_NOP_C));
            end
         endcase
         send_request(op, word, 1'b0, '0);
      end

      // drain the result side, then let the pipeline settle
      req_valid <= 1'b0;
      burst_mode = 1'b1;
      do @(posedge clock); while (expected_beats.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("covered %0d requests (%0d directed): %0d pushes refused at capacity,",
               requests_sent, DIRECTED_ROWS, refused_pushes);
      $display("%0d pops from empty, peak occupancy %0d of %0d, %0d mismatches",
               empty_pops, peak_count, CAPACITY, error_count);
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
